// ----- rtl/next_permutation_engine_top_assert.svh -----
// Assertion macros shared by the block's top level.
`ifndef NEXT_PERMUTATION_ENGINE_TOP_ASSERT_SVH
`define NEXT_PERMUTATION_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define NPE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define NPE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/npe_pkg.sv -----
package npe_pkg;

    // Default store depth.
    localparam int MAX_LEN_DEF = 16;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_START,
        ST_PIV_RD,
        ST_PIV_CMP,
        ST_SUC_RD,
        ST_SUC_CMP,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_OUT
    } npe_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ld;          // store an accepted element
        logic seq_done;    // sequence fully emitted, clear count and overflow
        logic adv_clr;
        logic adv_set;
        logic scan_start;  // index to the last stored position
        logic emit_start;  // index to position zero
        logic idx_dec;
        logic idx_inc;
        logic prev_ld;
        logic pivot_ld;
        logic k_ld;
        logic emit_addr;   // read address follows the output mapping
        logic out_ld;
    } npe_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic short_seq;   // fewer than two elements stored
        logic count_nz;
        logic idx_top;     // index sits at the last stored position
        logic idx_zero;
        logic lt_prev;     // read element is below its right neighbor
        logic gt_pval;     // read element is above the pivot value
    } npe_status_t;

endpackage

// ----- rtl/npe_datapath.sv -----
module npe_datapath #(
    parameter int MAX_LEN = npe_pkg::MAX_LEN_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         elem,
    input  npe_pkg::npe_cmd_t  cmd,
    output npe_pkg::npe_status_t st,
    output logic [7:0]         out_elem,
    output logic               out_last,
    output logic               advanced,
    output logic               overflow
);
    import npe_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);

    logic [7:0]    mem [MAX_LEN];

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          adv_reg, adv_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [7:0]    prev_reg;
    logic [AW-1:0] piv_reg;
    logic [7:0]    pval_reg;
    logic [AW-1:0] k_reg;
    logic [7:0]    rd_data_reg;
    logic          sub_reg, sub_next;
    logic [7:0]    out_elem_reg;
    logic          out_last_reg;

    logic          full;
    logic [AW-1:0] top_idx;
    logic          past_piv;
    logic          at_piv;
    logic [AW-1:0] mirror;
    logic [AW-1:0] rd_addr;

    assign full    = (count_reg == CW'(MAX_LEN));
    assign top_idx = AW'(count_reg - CW'(1));

    // Output position mapping: the pivot takes the successor, the suffix is mirrored.
    assign past_piv = adv_reg && (idx_reg > piv_reg);
    assign at_piv   = adv_reg && (idx_reg == piv_reg);
    assign mirror   = AW'((CW + 1)'(count_reg) + (CW + 1)'(piv_reg) - (CW + 1)'(idx_reg));

    always_comb
    begin
        if (!cmd.emit_addr) begin
            rd_addr = idx_reg;
        end else if (at_piv) begin
            rd_addr = k_reg;
        end else if (past_piv) begin
            rd_addr = mirror;
        end else begin
            rd_addr = idx_reg;
        end
        sub_next = cmd.emit_addr && past_piv && (mirror == k_reg);
    end

    // Element store with one write and one registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.ld && !full) begin
            mem[count_reg[AW-1:0]] <= elem;
        end
        rd_data_reg <= mem[rd_addr];
        sub_reg     <= sub_next;
    end

    // Next values of the control registers.
    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        adv_next   = adv_reg;
        if (cmd.ld) begin
            if (full) begin
                ovf_next = 1'b1;
            end else begin
                count_next = count_reg + CW'(1);
            end
        end
        if (cmd.seq_done) begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
        if (cmd.adv_clr) begin
            adv_next = 1'b0;
        end
        if (cmd.adv_set) begin
            adv_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            adv_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            adv_reg   <= adv_next;
        end
    end

    // Scan and emit index.
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.scan_start) begin
            idx_next = top_idx;
        end else if (cmd.emit_start) begin
            idx_next = '0;
        end else if (cmd.idx_dec) begin
            idx_next = idx_reg - AW'(1);
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + AW'(1);
        end
    end

    // Scan results and the output register.
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.prev_ld) begin
            prev_reg <= rd_data_reg;
        end
        if (cmd.pivot_ld) begin
            piv_reg  <= idx_reg;
            pval_reg <= rd_data_reg;
        end
        if (cmd.k_ld) begin
            k_reg <= idx_reg;
        end
        if (cmd.out_ld) begin
            out_elem_reg <= sub_reg ? pval_reg : rd_data_reg;
            out_last_reg <= (idx_reg == top_idx);
        end
    end

    // Status toward the controller.
    assign st.short_seq = (count_reg <= CW'(1));
    assign st.count_nz  = (count_reg != '0);
    assign st.idx_top   = (idx_reg == top_idx);
    assign st.idx_zero  = (idx_reg == '0);
    assign st.lt_prev   = (rd_data_reg < prev_reg);
    assign st.gt_pval   = (rd_data_reg > pval_reg);

    assign out_elem = out_elem_reg;
    assign out_last = out_last_reg;
    assign advanced = adv_reg;
    assign overflow = ovf_reg;

endmodule

// ----- rtl/npe_ctrl.sv -----
module npe_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 elem_valid,
    output logic                 elem_ready,
    input  logic                 last,
    output logic                 res_valid,
    input  logic                 res_ready,
    input  npe_pkg::npe_status_t st,
    output npe_pkg::npe_cmd_t    cmd
);
    import npe_pkg::*;

    npe_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (elem_valid && last) begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = st.short_seq ? ST_EMIT_RD : ST_PIV_RD;
            end
            ST_PIV_RD:
            begin
                state_next = ST_PIV_CMP;
            end
            ST_PIV_CMP:
            begin
                if (!st.idx_top && st.lt_prev) begin
                    state_next = ST_SUC_RD;
                end else if (st.idx_zero) begin
                    state_next = ST_EMIT_RD;
                end else begin
                    state_next = ST_PIV_RD;
                end
            end
            ST_SUC_RD:
            begin
                state_next = ST_SUC_CMP;
            end
            ST_SUC_CMP:
            begin
                state_next = st.gt_pval ? ST_EMIT_RD : ST_SUC_RD;
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                if (res_ready) begin
                    state_next = st.idx_top ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Commands and handshake outputs.
    always_comb
    begin
        cmd        = '0;
        elem_ready = 1'b0;
        res_valid  = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                elem_ready = 1'b1;
                cmd.ld     = elem_valid;
            end
            ST_START:
            begin
                cmd.adv_clr = 1'b1;
                if (st.short_seq) begin
                    cmd.emit_start = 1'b1;
                end else begin
                    cmd.scan_start = 1'b1;
                end
            end
            ST_PIV_CMP:
            begin
                cmd.prev_ld = 1'b1;
                if (!st.idx_top && st.lt_prev) begin
                    cmd.pivot_ld   = 1'b1;
                    cmd.adv_set    = 1'b1;
                    cmd.scan_start = 1'b1;
                end else if (st.idx_zero) begin
                    cmd.emit_start = 1'b1;
                end else begin
                    cmd.idx_dec = 1'b1;
                end
            end
            ST_SUC_CMP:
            begin
                if (st.gt_pval) begin
                    cmd.k_ld       = 1'b1;
                    cmd.emit_start = 1'b1;
                end else begin
                    cmd.idx_dec = 1'b1;
                end
            end
            ST_EMIT_RD:
            begin
                cmd.emit_addr = 1'b1;
            end
            ST_EMIT_LD:
            begin
                cmd.out_ld = 1'b1;
            end
            ST_EMIT_OUT:
            begin
                res_valid = 1'b1;
                if (res_ready) begin
                    if (st.idx_top) begin
                        cmd.seq_done = 1'b1;
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/next_permutation_engine_top.sv -----
// Channel   Handshake               Payload
// input     elem_valid/elem_ready   elem, last
// result    res_valid/res_ready     out_elem, out_last, advanced, overflow
//
// Loading accepts one element per cycle. After the last element, the pivot scan
// and the successor scan each visit one position at a time through a read and a
// compare state, bounded by the single read port of the element store. Each result
// passes the read, load and output states and waits on res_ready. Reset returns the
// sequencer to loading with an empty store; no input is taken in scan or emission.
`include "next_permutation_engine_top_assert.svh"

module next_permutation_engine_top #(
    parameter int MAX_LEN = npe_pkg::MAX_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       elem_valid,
    output logic       elem_ready,
    input  logic [7:0] elem,
    input  logic       last,
    output logic       res_valid,
    input  logic       res_ready,
    output logic [7:0] out_elem,
    output logic       out_last,
    output logic       advanced,
    output logic       overflow
);
    import npe_pkg::*;

    npe_cmd_t    cmd;
    npe_status_t st;

    // Sequencer.
    npe_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .elem_valid (elem_valid),
        .elem_ready (elem_ready),
        .last       (last),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .st         (st),
        .cmd        (cmd)
    );

    // Element store, scan registers and output register.
    npe_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .elem     (elem),
        .cmd      (cmd),
        .st       (st),
        .out_elem (out_elem),
        .out_last (out_last),
        .advanced (advanced),
        .overflow (overflow)
    );

    // Loading and emitting never overlap.
    `NPE_ASSERT_NOW(a_phase_excl, res_valid, !elem_ready, "input ready during emission")
    // A final element stops loading on the next cycle.
    `NPE_ASSERT_NEXT(a_last_stops, elem_valid && elem_ready && last, !elem_ready, "load after last")
    // A result is only offered with a non-empty store.
    `NPE_ASSERT_NOW(a_res_nonempty, res_valid, st.count_nz, "result with empty store")
    // A sequence shorter than two cannot advance.
    `NPE_ASSERT_NOW(a_short_noadv, res_valid && st.short_seq, !advanced, "short sequence advanced")

endmodule
